FILE: sv/tcce_pkg.sv
package tcce_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    typedef enum logic [1:0] {
        ACT_PRINT,
        ACT_CLEAR,
        ACT_SET,
        ACT_READ
    } t_action;

    // class of the byte carried by a print word
    typedef enum logic [2:0] {
        CH_NULL,
        CH_NL,
        CH_BS,
        CH_TAB,
        CH_PRINT
    } t_chr;

    // cell sweeps the datapath can run over the screen store
    typedef enum logic [2:0] {
        WK_INIT,
        WK_CLEAR,
        WK_LINE,
        WK_CHAR,
        WK_BS,
        WK_COPY,
        WK_LAST,
        WK_READ
    } t_walk;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_STEP,
        CUR_SET,
        CUR_HOME
    } t_cur_op;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_byte;
        logic [7:0] column;
        logic [7:0] row;
    } t_in;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_linear;
        logic [7:0]  read_char;
        logic        scrolled;
    } t_out;

    typedef struct packed {
        logic    capture;
        logic    walk_go;
        t_walk   walk;
        t_cur_op cur_op;
        logic    set_scroll;
    } t_dp_cmd;

    typedef struct packed {
        logic    busy;
        t_action action;
        t_chr    chr;
        logic    bs_stuck;
        logic    step_scroll;
        logic    read_ok;
    } t_dp_stat;

endpackage

FILE: sv/text_console_char_engine.sv
// Text console engine: holds a ROWS x COLUMNS screen of 16-bit cells (character in the low
// byte, attribute in the high byte) plus a cursor. A word is taken when start is high and
// busy is low; its result is valid on o_result while o_strobe is high for exactly one cycle and
// cannot be held off. The screen store has one write and one read port and is visited one
// cell per clock: after reset busy stays high while the store is cleared. Set cursor, null,
// tab, backspace at the top-left corner and out-of-range reads leave the store alone; a
// printed character, any other backspace or an in-range read visits one cell; a newline
// blanks the cells from the cursor to the end of the row; clear screen visits every cell; a
// scroll adds a row copy plus blanking the last row. The next word can be accepted in the
// strobe cycle.
module text_console_char_engine #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  tcce_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_strobe,
    output tcce_pkg::t_out o_result
);
    import tcce_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tcce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    tcce_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

FILE: sv/tcce_ram.sv
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tcce_datapath.sv
module tcce_datapath #(
    parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcce_pkg::t_in      i_item,
    input  tcce_pkg::t_dp_cmd  i_cmd,
    output tcce_pkg::t_dp_stat o_stat,
    output tcce_pkg::t_out     o_result
);
    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);
    localparam int LW    = 17;

    localparam logic [7:0] BLANK_CHAR = 8'h20;
    localparam logic [7:0] CHR_NUL    = 8'h00;
    localparam logic [7:0] CHR_BS     = 8'h08;
    localparam logic [7:0] CHR_TAB    = 8'h09;
    localparam logic [7:0] CHR_NL     = 8'h0A;

    typedef enum logic [2:0] {
        WM_INIT,
        WM_COPY,
        WM_BLANK,
        WM_CHAR,
        WM_READ
    } t_wmode;

    t_in           r_item;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [7:0]    r_read_char;
    logic          r_scrolled;

    logic          r_active;
    logic [AW-1:0] r_addr;
    logic [NW-1:0] r_cnt;
    t_wmode        r_mode;
    logic          r_pend;
    logic [AW-1:0] r_waddr;
    t_wmode        r_pmode;

    t_chr          chr;
    logic [CW:0]   col_p1;
    logic [CW:0]   tab_sum;
    logic [CW:0]   tab_col;
    logic [RW:0]   row_p1;
    logic          overflow;
    logic          wrap;
    logic [CW-1:0] step_col;
    logic [RW-1:0] step_row;

    logic [7:0]    sel_row;
    logic [7:0]    sel_col;
    logic [LW-1:0] lin;
    logic [LW-1:0] lin_cur;
    logic [AW-1:0] walk_addr;
    logic [NW-1:0] walk_cnt;
    t_wmode        walk_mode;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [15:0]   ram_q;

    always_comb begin
        case (r_item.char_byte)
            CHR_NUL: chr = CH_NULL;
            CHR_NL:  chr = CH_NL;
            CHR_BS:  chr = CH_BS;
            CHR_TAB: chr = CH_TAB;
            default: chr = CH_PRINT;
        endcase
    end

    assign col_p1   = (CW + 1)'(r_col) + (CW + 1)'(1);
    assign tab_sum  = (CW + 1)'(r_col) + (CW + 1)'(8);
    assign tab_col  = {tab_sum[CW:3], 3'b000};
    assign row_p1   = (RW + 1)'(r_row) + (RW + 1)'(1);
    assign overflow = row_p1 >= (RW + 1)'(ROWS);

    // cursor after a print word, before any scroll
    always_comb begin
        step_col = r_col;
        step_row = r_row;
        wrap     = 1'b0;
        case (chr)
            CH_NL: begin
                wrap = 1'b1;
            end
            CH_BS: begin
                if (r_col != '0) begin
                    step_col = r_col - CW'(1);
                end else if (r_row != '0) begin
                    step_row = r_row - RW'(1);
                    step_col = CW'(COLUMNS - 1);
                end
            end
            CH_TAB: begin
                if (tab_col >= (CW + 1)'(COLUMNS)) begin
                    wrap = 1'b1;
                end else begin
                    step_col = tab_col[CW-1:0];
                end
            end
            CH_PRINT: begin
                if (col_p1 >= (CW + 1)'(COLUMNS)) begin
                    wrap = 1'b1;
                end else begin
                    step_col = col_p1[CW-1:0];
                end
            end
            default: begin
                step_col = r_col;
            end
        endcase
        if (wrap) begin
            step_col = '0;
            step_row = overflow ? RW'(ROWS - 1) : row_p1[RW-1:0];
        end
    end

    // start cell, length and write mode of the requested sweep
    always_comb begin
        case (i_cmd.walk)
            WK_LINE, WK_CHAR: begin
                sel_row = 8'(r_row);
                sel_col = 8'(r_col);
            end
            WK_BS: begin
                sel_row = 8'(step_row);
                sel_col = 8'(step_col);
            end
            WK_READ: begin
                sel_row = r_item.row;
                sel_col = r_item.column;
            end
            default: begin
                sel_row = '0;
                sel_col = '0;
            end
        endcase
        lin = LW'(sel_row) * LW'(COLUMNS) + LW'(sel_col);
        case (i_cmd.walk)
            WK_INIT: begin
                walk_addr = '0;
                walk_cnt  = NW'(CELLS);
                walk_mode = WM_INIT;
            end
            WK_CLEAR: begin
                walk_addr = '0;
                walk_cnt  = NW'(CELLS);
                walk_mode = WM_BLANK;
            end
            WK_LINE: begin
                walk_addr = lin[AW-1:0];
                walk_cnt  = NW'(COLUMNS) - NW'(r_col);
                walk_mode = WM_BLANK;
            end
            WK_CHAR: begin
                walk_addr = lin[AW-1:0];
                walk_cnt  = NW'(1);
                walk_mode = WM_CHAR;
            end
            WK_BS: begin
                walk_addr = lin[AW-1:0];
                walk_cnt  = NW'(1);
                walk_mode = WM_BLANK;
            end
            WK_COPY: begin
                walk_addr = AW'(COLUMNS);
                walk_cnt  = NW'(CELLS - COLUMNS);
                walk_mode = WM_COPY;
            end
            WK_LAST: begin
                walk_addr = AW'(CELLS - COLUMNS);
                walk_cnt  = NW'(COLUMNS);
                walk_mode = WM_BLANK;
            end
            WK_READ: begin
                walk_addr = lin[AW-1:0];
                walk_cnt  = NW'(1);
                walk_mode = WM_READ;
            end
            default: begin
                walk_addr = '0;
                walk_cnt  = NW'(1);
                walk_mode = WM_READ;
            end
        endcase
    end

    // read one cell a cycle, write it back in the next cycle (the init pass only writes, a read only reads)
    assign ram_re    = r_active && (r_mode != WM_INIT);
    assign ram_we    = (r_active && (r_mode == WM_INIT)) ||
                       (r_pend && (r_pmode != WM_READ));
    assign ram_waddr = r_pend ? r_waddr : r_addr;

    // the clearing pass writes zeros whenever no write-back is pending
    always_comb begin
        case (r_pend ? r_pmode : WM_INIT)
            WM_COPY:  ram_wdata = ram_q;
            WM_BLANK: ram_wdata = {ram_q[15:8], BLANK_CHAR};
            WM_CHAR:  ram_wdata = {ram_q[15:8], r_item.char_byte};
            default:  ram_wdata = '0;
        endcase
    end

    tcce_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.walk_go) begin
            r_addr <= walk_addr;
            r_mode <= walk_mode;
        end else if (r_active) begin
            r_addr <= r_addr + AW'(1);
        end
        r_waddr <= (r_mode == WM_COPY) ? r_addr - AW'(COLUMNS) : r_addr;
        r_pmode <= r_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_read_char <= '0;
            r_scrolled  <= 1'b0;
        end else begin
            if (i_cmd.walk_go) begin
                r_active <= 1'b1;
                r_cnt    <= walk_cnt;
            end else if (r_active) begin
                r_cnt <= r_cnt - NW'(1);
                if (r_cnt == NW'(1)) begin
                    r_active <= 1'b0;
                end
            end
            r_pend <= r_active && (r_mode != WM_INIT);

            if (i_cmd.capture) begin
                r_read_char <= '0;
                r_scrolled  <= 1'b0;
            end else begin
                if (r_pend && (r_pmode == WM_READ)) begin
                    r_read_char <= ram_q[7:0];
                end
                if (i_cmd.set_scroll) begin
                    r_scrolled <= 1'b1;
                end
            end

            case (i_cmd.cur_op)
                CUR_STEP: begin
                    r_col <= step_col;
                    r_row <= step_row;
                end
                CUR_SET: begin
                    r_col <= (r_item.column >= 8'(COLUMNS)) && (COLUMNS < 256) ?
                             CW'(COLUMNS - 1) : CW'(r_item.column);
                    r_row <= (r_item.row >= 8'(ROWS)) && (ROWS < 256) ?
                             RW'(ROWS - 1) : RW'(r_item.row);
                end
                CUR_HOME: begin
                    r_col <= '0;
                    r_row <= '0;
                end
                default: begin
                    r_col <= r_col;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.busy        = r_active || r_pend;
        o_stat.action      = t_action'(r_item.action);
        o_stat.chr         = chr;
        o_stat.bs_stuck    = (r_col == '0) && (r_row == '0);
        o_stat.step_scroll = wrap && overflow;
        o_stat.read_ok     = (LW'(r_item.column) < LW'(COLUMNS)) &&
                             (LW'(r_item.row) < LW'(ROWS));
    end

    assign lin_cur = LW'(r_row) * LW'(COLUMNS) + LW'(r_col);

    always_comb begin
        o_result.cursor_col    = 7'(r_col);
        o_result.cursor_row    = 5'(r_row);
        o_result.cursor_linear = lin_cur[10:0];
        o_result.read_char     = r_read_char;
        o_result.scrolled      = r_scrolled;
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CW + 1)'(r_col) < (CW + 1)'(COLUMNS)) && ((RW + 1)'(r_row) < (RW + 1)'(ROWS)))
        else $error("cursor left the screen");

    a_no_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != r_addr))
        else $error("screen write and read hit the same cell");

    a_write_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && (r_mode != WM_INIT) && (r_mode != WM_READ)) |=> ram_we)
        else $error("cell read without its write-back");

endmodule

FILE: sv/tcce_ctrl.sv
module tcce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tcce_pkg::t_dp_stat i_stat,
    output tcce_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_strobe
);
    import tcce_pkg::*;

    typedef enum logic [2:0] {
        S_BOOT,
        S_BOOT_WAIT,
        S_IDLE,
        S_DECODE,
        S_WAIT_WALK,
        S_WAIT_COPY,
        S_WAIT_LAST,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_scroll;
    logic   r_strobe;

    always_comb begin
        o_cmd.capture    = 1'b0;
        o_cmd.walk_go    = 1'b0;
        o_cmd.walk       = WK_INIT;
        o_cmd.cur_op     = CUR_HOLD;
        o_cmd.set_scroll = 1'b0;
        case (r_state)
            S_BOOT: begin
                o_cmd.walk_go = 1'b1;
                o_cmd.walk    = WK_INIT;
            end
            S_IDLE: begin
                o_cmd.capture = i_start;
            end
            S_DECODE: begin
                case (i_stat.action)
                    ACT_PRINT: begin
                        o_cmd.cur_op     = CUR_STEP;
                        o_cmd.set_scroll = i_stat.step_scroll;
                        case (i_stat.chr)
                            CH_NL: begin
                                o_cmd.walk_go = 1'b1;
                                o_cmd.walk    = WK_LINE;
                            end
                            CH_PRINT: begin
                                o_cmd.walk_go = 1'b1;
                                o_cmd.walk    = WK_CHAR;
                            end
                            CH_BS: begin
                                o_cmd.walk_go = !i_stat.bs_stuck;
                                o_cmd.walk    = WK_BS;
                            end
                            default: begin
                                o_cmd.walk_go = 1'b0;
                            end
                        endcase
                    end
                    ACT_CLEAR: begin
                        o_cmd.walk_go = 1'b1;
                        o_cmd.walk    = WK_CLEAR;
                        o_cmd.cur_op  = CUR_HOME;
                    end
                    ACT_SET: begin
                        o_cmd.cur_op = CUR_SET;
                    end
                    ACT_READ: begin
                        o_cmd.walk_go = i_stat.read_ok;
                        o_cmd.walk    = WK_READ;
                    end
                    default: begin
                        o_cmd.walk_go = 1'b0;
                    end
                endcase
            end
            S_WAIT_WALK: begin
                o_cmd.walk_go = !i_stat.busy && r_scroll;
                o_cmd.walk    = WK_COPY;
            end
            S_WAIT_COPY: begin
                o_cmd.walk_go = !i_stat.busy;
                o_cmd.walk    = WK_LAST;
            end
            default: begin
                o_cmd.walk_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_BOOT;
            r_scroll <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_BOOT: begin
                    r_state <= S_BOOT_WAIT;
                end
                S_BOOT_WAIT: begin
                    if (!i_stat.busy) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_scroll <= (i_stat.action == ACT_PRINT) && i_stat.step_scroll;
                    r_state  <= S_WAIT_WALK;
                end
                S_WAIT_WALK: begin
                    if (!i_stat.busy) begin
                        r_state <= r_scroll ? S_WAIT_COPY : S_DONE;
                    end
                end
                S_WAIT_COPY: begin
                    if (!i_stat.busy) begin
                        r_state <= S_WAIT_LAST;
                    end
                end
                S_WAIT_LAST: begin
                    if (!i_stat.busy) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.busy |-> ((r_state != S_IDLE) && (r_state != S_DONE)))
        else $error("sweep still running while result is reported");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && (r_state == S_IDLE)) |=> (r_state == S_DECODE))
        else $error("accepted word not decoded");

    // the boot sweep request seen while reset is held does not launch anything
    a_walk_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && o_cmd.walk_go) |=> i_stat.busy)
        else $error("sweep launched but datapath not busy");

endmodule
